FILE: rtl/gdis_pkg.sv
package gdis_pkg;

  // Sizes of the sample store and the configuration register.
  localparam int MAX_SAMPLES    = 4096;
  localparam int CFG_W          = 13;
  localparam int IDX_W          = $clog2(MAX_SAMPLES);
  localparam int CODES_PER_BYTE = 4;
  localparam int ADDR_W         = IDX_W - 2;
  localparam int RAM_DEPTH      = MAX_SAMPLES / CODES_PER_BYTE;
  localparam int BYTE_W         = 8;

  // Fixed-point format of the results.
  localparam int FRAC_BITS = 16;
  localparam int SD_EXTRA  = 15;
  localparam int VAL_W     = 32;

  // Datapath widths.
  localparam int CNT_W      = CFG_W;
  localparam int SUM_W      = CNT_W + 1;
  localparam int SQ_W       = CNT_W + 2;
  localparam int PROD_W     = CNT_W + SQ_W;
  localparam int SQRT_STEPS = (PROD_W + 2 * SD_EXTRA + 1) / 2;
  localparam int X_W        = 2 * SQRT_STEPS;
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int SREM_W     = ROOT_W + 3;
  localparam int DEN_W      = ROOT_W;
  localparam int DREM_W     = DEN_W + 1;
  localparam int NUM_W      = SUM_W + FRAC_BITS + SD_EXTRA;
  localparam int STEP_W     = $clog2(NUM_W + 1);

  // Configuration port.
  localparam int  PADDR_W          = 3;
  localparam int  PDATA_W          = 32;
  localparam logic REG_SAMPLE_COUNT = 1'b0;

  // Input item kinds.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_REQ  = 1'b1;

  // Packed genotype codes.
  localparam logic [1:0] CODE_HOM0 = 2'b00;
  localparam logic [1:0] CODE_MISS = 2'b01;
  localparam logic [1:0] CODE_HET  = 2'b10;
  localparam logic [1:0] CODE_HOM2 = 2'b11;

  typedef enum logic [1:0] {
    CLS_G0,
    CLS_G1,
    CLS_G2,
    CLS_MISS
  } class_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_STATS,
    ST_PROD,
    ST_DIFF,
    ST_SQRT,
    ST_DIVINIT,
    ST_DIV,
    ST_DIVEND,
    ST_DRAIN,
    ST_DREAD
  } state_t;

  typedef struct packed {
    logic   clear;
    logic   load;
    logic   stats;
    logic   prod;
    logic   diff;
    logic   sqrt_step;
    logic   div_init;
    logic   div_step;
    logic   div_store;
    logic   drain_rd;
    logic   drain_out;
    class_t lvl;
  } cmd_t;

  typedef struct packed {
    logic load_last;
    logic out_valid;
    logic fin;
  } sts_t;

  // Maps a packed code to its genotype class.
  function automatic class_t code_class(input logic [1:0] code);
    class_t c;
    unique case (code)
      CODE_HOM0: c = CLS_G0;
      CODE_MISS: c = CLS_MISS;
      CODE_HET:  c = CLS_G1;
      CODE_HOM2: c = CLS_G2;
      default:   c = CLS_G0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/gdis_ram.sv
module gdis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/gdis_ctrl.sv
module gdis_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr,
  input  logic              in_valid,
  input  logic              in_mode,
  output logic              in_ready,
  input  gdis_pkg::sts_t    sts,
  output gdis_pkg::cmd_t    cmd,
  output gdis_pkg::state_t  state
);

  gdis_pkg::state_t                state_next;
  logic [gdis_pkg::STEP_W-1:0]     step;
  logic [gdis_pkg::STEP_W-1:0]     step_next;
  gdis_pkg::class_t                lvl;
  gdis_pkg::class_t                lvl_next;
  logic                            accept;

  // State, step counter and level index registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gdis_pkg::ST_LOAD;
      step  <= '0;
      lvl   <= gdis_pkg::CLS_G0;
    end else begin
      state <= state_next;
      step  <= step_next;
      lvl   <= lvl_next;
    end
  end

  assign accept = in_valid & in_ready;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    step_next  = step;
    lvl_next   = lvl;
    cmd        = '0;
    cmd.lvl    = lvl;
    in_ready   = 1'b0;
    if (cfg_wr) begin
      cmd.clear  = 1'b1;
      state_next = gdis_pkg::ST_LOAD;
    end else begin
      unique case (state)
        gdis_pkg::ST_LOAD: begin
          in_ready = 1'b1;
          if (accept && in_mode == gdis_pkg::MODE_LOAD) begin
            cmd.load = 1'b1;
            if (sts.load_last) begin
              state_next = gdis_pkg::ST_STATS;
            end
          end
        end
        gdis_pkg::ST_STATS: begin
          cmd.stats  = 1'b1;
          state_next = gdis_pkg::ST_PROD;
        end
        gdis_pkg::ST_PROD: begin
          cmd.prod   = 1'b1;
          state_next = gdis_pkg::ST_DIFF;
        end
        gdis_pkg::ST_DIFF: begin
          cmd.diff   = 1'b1;
          step_next  = '0;
          state_next = gdis_pkg::ST_SQRT;
        end
        gdis_pkg::ST_SQRT: begin
          cmd.sqrt_step = 1'b1;
          if (step == gdis_pkg::STEP_W'(gdis_pkg::SQRT_STEPS - 1)) begin
            lvl_next   = gdis_pkg::CLS_G0;
            state_next = gdis_pkg::ST_DIVINIT;
          end else begin
            step_next = step + gdis_pkg::STEP_W'(1);
          end
        end
        gdis_pkg::ST_DIVINIT: begin
          cmd.div_init = 1'b1;
          step_next    = '0;
          state_next   = gdis_pkg::ST_DIV;
        end
        gdis_pkg::ST_DIV: begin
          cmd.div_step = 1'b1;
          if (step == gdis_pkg::STEP_W'(gdis_pkg::NUM_W - 1)) begin
            state_next = gdis_pkg::ST_DIVEND;
          end else begin
            step_next = step + gdis_pkg::STEP_W'(1);
          end
        end
        gdis_pkg::ST_DIVEND: begin
          cmd.div_store = 1'b1;
          if (lvl == gdis_pkg::CLS_G2) begin
            state_next = gdis_pkg::ST_DRAIN;
          end else begin
            lvl_next   = gdis_pkg::class_t'(lvl + 2'd1);
            state_next = gdis_pkg::ST_DIVINIT;
          end
        end
        gdis_pkg::ST_DRAIN: begin
          in_ready = ~sts.out_valid;
          if (accept && in_mode == gdis_pkg::MODE_REQ) begin
            cmd.drain_rd = 1'b1;
            state_next   = gdis_pkg::ST_DREAD;
          end
        end
        gdis_pkg::ST_DREAD: begin
          cmd.drain_out = 1'b1;
          state_next    = sts.fin ? gdis_pkg::ST_LOAD : gdis_pkg::ST_DRAIN;
        end
        default: begin
          state_next = gdis_pkg::ST_LOAD;
        end
      endcase
    end
  end

endmodule

FILE: rtl/gdis_dp.sv
module gdis_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  gdis_pkg::cmd_t                  cmd,
  output gdis_pkg::sts_t                  sts,
  input  logic                            cfg_wr,
  input  logic [gdis_pkg::CFG_W-1:0]      cfg_data,
  output logic [gdis_pkg::CFG_W-1:0]      sample_count,
  input  logic [gdis_pkg::BYTE_W-1:0]     in_byte,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [gdis_pkg::VAL_W-1:0]      out_value,
  output logic [gdis_pkg::IDX_W-1:0]      out_index,
  output logic                            out_last
);

  logic [gdis_pkg::CNT_W-1:0]  counts [4];
  logic [2:0]                  inc [4];
  logic [gdis_pkg::ADDR_W-1:0] blk;
  logic [gdis_pkg::ADDR_W:0]   blk_inc;
  logic [gdis_pkg::IDX_W-1:0]  drain_pos;
  logic [gdis_pkg::CFG_W-1:0]  cfg_clamped;
  logic                        marker_clear;

  gdis_pkg::class_t            imp;
  gdis_pkg::class_t            imp_next;
  logic [gdis_pkg::CNT_W-1:0]  c1a;
  logic [gdis_pkg::CNT_W-1:0]  c2a;
  logic [gdis_pkg::SUM_W-1:0]  s;
  logic [gdis_pkg::SQ_W-1:0]   q;
  logic [gdis_pkg::PROD_W-1:0] nq;
  logic [gdis_pkg::PROD_W-1:0] ss;
  logic [gdis_pkg::PROD_W-1:0] d;

  logic [gdis_pkg::X_W-1:0]    sx;
  logic [gdis_pkg::SREM_W-1:0] srem;
  logic [gdis_pkg::SREM_W-1:0] srem_sh;
  logic [gdis_pkg::SREM_W-1:0] trial;
  logic [gdis_pkg::ROOT_W-1:0] root;
  logic                        d_zero;

  logic [gdis_pkg::DEN_W-1:0]  den;
  logic [gdis_pkg::SUM_W-1:0]  gn;
  logic [gdis_pkg::SUM_W-1:0]  mag;
  logic                        neg_in;
  logic                        neg;
  logic [gdis_pkg::NUM_W-1:0]  dnum;
  logic [gdis_pkg::NUM_W-1:0]  quo;
  logic [gdis_pkg::DREM_W-1:0] drem;
  logic [gdis_pkg::DREM_W-1:0] drem_sh;
  logic                        rup;
  logic [gdis_pkg::NUM_W:0]    rq;
  logic [gdis_pkg::VAL_W-1:0]  lvl_val;
  logic [gdis_pkg::VAL_W-1:0]  level [3];

  logic [gdis_pkg::BYTE_W-1:0] ram_rdata;
  logic [1:0]                  rd_code;
  gdis_pkg::class_t            rd_cls;

  // Sample count register, clamped into the supported range.
  always_comb begin
    cfg_clamped = cfg_data;
    if (cfg_data == '0) begin
      cfg_clamped = gdis_pkg::CFG_W'(1);
    end else if (cfg_data > gdis_pkg::CFG_W'(gdis_pkg::MAX_SAMPLES)) begin
      cfg_clamped = gdis_pkg::CFG_W'(gdis_pkg::MAX_SAMPLES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= gdis_pkg::CFG_W'(1);
    end else if (cfg_wr) begin
      sample_count <= cfg_clamped;
    end
  end

  // Per-class increments for the four codes of a loaded byte.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      inc[k] = '0;
    end
    for (int i = 0; i < gdis_pkg::CODES_PER_BYTE; i++) begin
      if (gdis_pkg::CFG_W'({blk, 2'b00}) + gdis_pkg::CFG_W'(i) < sample_count) begin
        inc[gdis_pkg::code_class(in_byte[2*i +: 2])] =
          inc[gdis_pkg::code_class(in_byte[2*i +: 2])] + 3'd1;
      end
    end
  end

  assign blk_inc       = (gdis_pkg::ADDR_W + 1)'(blk) + (gdis_pkg::ADDR_W + 1)'(1);
  assign sts.load_last = gdis_pkg::CFG_W'({blk_inc, 2'b00}) >= sample_count;
  assign sts.fin       = gdis_pkg::CFG_W'(drain_pos) + gdis_pkg::CFG_W'(1) >= sample_count;
  assign marker_clear  = cmd.clear | (cmd.drain_out & sts.fin);

  // Class counts, byte count and drain position.
  always_ff @(posedge clk) begin
    if (rst || marker_clear) begin
      for (int k = 0; k < 4; k++) begin
        counts[k] <= '0;
      end
      blk       <= '0;
      drain_pos <= '0;
    end else begin
      if (cmd.load) begin
        for (int k = 0; k < 4; k++) begin
          counts[k] <= counts[k] + gdis_pkg::CNT_W'(inc[k]);
        end
        blk <= blk + gdis_pkg::ADDR_W'(1);
      end
      if (cmd.drain_out) begin
        drain_pos <= drain_pos + gdis_pkg::IDX_W'(1);
      end
    end
  end

  // Genotype store: one packed byte per entry.
  gdis_ram #(
    .WIDTH (gdis_pkg::BYTE_W),
    .DEPTH (gdis_pkg::RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (blk),
    .wdata (in_byte),
    .raddr (drain_pos[gdis_pkg::IDX_W-1:2]),
    .rdata (ram_rdata)
  );

  // Imputation class and sums after the last byte.
  always_comb begin
    imp_next = gdis_pkg::CLS_G0;
    if (counts[1] > counts[0]) begin
      imp_next = gdis_pkg::CLS_G1;
    end
    if (counts[2] > counts[imp_next]) begin
      imp_next = gdis_pkg::CLS_G2;
    end
    c1a = counts[1];
    c2a = counts[2];
    if (imp_next == gdis_pkg::CLS_G1) begin
      c1a = counts[1] + counts[3];
    end
    if (imp_next == gdis_pkg::CLS_G2) begin
      c2a = counts[2] + counts[3];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stats) begin
      imp <= imp_next;
      s   <= gdis_pkg::SUM_W'(c1a) + {c2a, 1'b0};
      q   <= gdis_pkg::SQ_W'(c1a) + {c2a, 2'b00};
    end
    if (cmd.prod) begin
      nq <= gdis_pkg::PROD_W'(sample_count) * gdis_pkg::PROD_W'(q);
      ss <= gdis_pkg::PROD_W'(s) * gdis_pkg::PROD_W'(s);
    end
  end

  assign d = (nq > ss) ? nq - ss : '0;

  // Integer square root, two radicand bits per step.
  assign srem_sh = {srem[gdis_pkg::SREM_W-3:0], sx[gdis_pkg::X_W-1 -: 2]};
  assign trial   = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      sx     <= gdis_pkg::X_W'({d, {(2 * gdis_pkg::SD_EXTRA){1'b0}}});
      srem   <= '0;
      root   <= '0;
      d_zero <= (d == '0);
    end else if (cmd.sqrt_step) begin
      sx <= {sx[gdis_pkg::X_W-3:0], 2'b00};
      if (srem_sh >= trial) begin
        srem <= srem_sh - trial;
        root <= {root[gdis_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        srem <= srem_sh;
        root <= {root[gdis_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Numerator of one level: |g*N - S| scaled up.
  assign den = d_zero ? gdis_pkg::DEN_W'(sample_count) : root;

  always_comb begin
    unique case (cmd.lvl)
      gdis_pkg::CLS_G1: gn = gdis_pkg::SUM_W'(sample_count);
      gdis_pkg::CLS_G2: gn = {sample_count, 1'b0};
      default:          gn = '0;
    endcase
    neg_in = gn < s;
    mag    = neg_in ? s - gn : gn - s;
  end

  // Restoring division, one quotient bit per step.
  assign drem_sh = {drem[gdis_pkg::DREM_W-2:0], dnum[gdis_pkg::NUM_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      neg  <= neg_in;
      drem <= '0;
      quo  <= '0;
      if (d_zero) begin
        dnum <= gdis_pkg::NUM_W'(mag) << gdis_pkg::FRAC_BITS;
      end else begin
        dnum <= gdis_pkg::NUM_W'(mag) << (gdis_pkg::FRAC_BITS + gdis_pkg::SD_EXTRA);
      end
    end else if (cmd.div_step) begin
      dnum <= {dnum[gdis_pkg::NUM_W-2:0], 1'b0};
      if (drem_sh >= {1'b0, den}) begin
        drem <= drem_sh - {1'b0, den};
        quo  <= {quo[gdis_pkg::NUM_W-2:0], 1'b1};
      end else begin
        drem <= drem_sh;
        quo  <= {quo[gdis_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

  // Round to nearest and saturate to the signed result range.
  always_comb begin
    rup = {drem, 1'b0} >= {2'b00, den};
    rq  = {1'b0, quo} + (gdis_pkg::NUM_W + 1)'(rup);
    if (neg) begin
      if (rq > (gdis_pkg::NUM_W + 1)'(64'h8000_0000)) begin
        lvl_val = 32'h8000_0000;
      end else begin
        lvl_val = ~rq[gdis_pkg::VAL_W-1:0] + 32'd1;
      end
    end else begin
      if (rq > (gdis_pkg::NUM_W + 1)'(64'h7FFF_FFFF)) begin
        lvl_val = 32'h7FFF_FFFF;
      end else begin
        lvl_val = rq[gdis_pkg::VAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      unique case (cmd.lvl)
        gdis_pkg::CLS_G1: level[1] <= lvl_val;
        gdis_pkg::CLS_G2: level[2] <= lvl_val;
        default:          level[0] <= lvl_val;
      endcase
    end
  end

  // Drain: pick the sample's code and look up its level.
  always_comb begin
    rd_code = ram_rdata[2*drain_pos[1:0] +: 2];
    rd_cls  = gdis_pkg::code_class(rd_code);
    if (rd_cls == gdis_pkg::CLS_MISS) begin
      rd_cls = imp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.drain_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain_out) begin
      out_index <= drain_pos;
      out_last  <= sts.fin;
      unique case (rd_cls)
        gdis_pkg::CLS_G1: out_value <= level[1];
        gdis_pkg::CLS_G2: out_value <= level[2];
        default:          out_value <= level[0];
      endcase
    end
  end

  assign sts.out_valid = out_valid;

endmodule

FILE: rtl/genotype_decode_impute_standardize.sv
// Loading takes one packed byte per cycle, ceil(sample_count / 4) bytes per marker.
// After the last byte the statistics unit runs a square root and three divisions,
// each one result bit per cycle, with no input accepted meanwhile.
// Each drain request passes through the store read, the result register and the result
// transaction, which completes before the next request is taken.
// Reset is synchronous and active high; it sets sample_count to 1 and starts loading.
module genotype_decode_impute_standardize (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // packed_byte
  input  logic                           s_axis_tuser,  // mode
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [47:0]                    m_axis_tdata,  // standardized_value, sample_index
  output logic                           m_axis_tlast,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gdis_pkg::PADDR_W-1:0]   paddr,
  input  logic [gdis_pkg::PDATA_W-1:0]   pwdata,
  output logic [gdis_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  gdis_pkg::cmd_t                  cmd;
  gdis_pkg::sts_t                  sts;
  gdis_pkg::state_t                state;
  logic                            cfg_wr;
  logic [gdis_pkg::CFG_W-1:0]      sample_count;
  logic [gdis_pkg::VAL_W-1:0]      out_value;
  logic [gdis_pkg::IDX_W-1:0]      out_index;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == gdis_pkg::REG_SAMPLE_COUNT);
  assign prdata = (paddr[2] == gdis_pkg::REG_SAMPLE_COUNT) ?
                  gdis_pkg::PDATA_W'(sample_count) : '0;

  gdis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_wr),
    .in_valid (s_axis_tvalid),
    .in_mode  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  gdis_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_wr       (cfg_wr),
    .cfg_data     (pwdata[gdis_pkg::CFG_W-1:0]),
    .sample_count (sample_count),
    .in_byte      (s_axis_tdata),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .out_value    (out_value),
    .out_index    (out_index),
    .out_last     (m_axis_tlast)
  );

  // Result packing, value in the low bits.
  assign m_axis_tdata = {4'b0000, out_index, out_value};

  // A store read is only ever waited on right after a drain request.
  assert property (@(posedge clk) disable iff (rst)
    state == gdis_pkg::ST_DREAD |-> $past(state) == gdis_pkg::ST_DRAIN)
    else $error("store read without a drain request");

  // A drain request is taken only when the result register is free.
  assert property (@(posedge clk) disable iff (rst)
    (state == gdis_pkg::ST_DRAIN && s_axis_tready) |-> !m_axis_tvalid)
    else $error("drain request accepted over a pending result");

  // A delivered level always shows up as a valid result.
  assert property (@(posedge clk) disable iff (rst)
    cmd.drain_out |=> m_axis_tvalid)
    else $error("result lost after store read");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;   // packed_byte
  logic              s_axis_tuser = 1'b0; // mode
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [47:0]       m_axis_tdata;        // standardized_value, sample_index
  logic              m_axis_tlast;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [gdis_pkg::PADDR_W-1:0] paddr = '0;
  logic [gdis_pkg::PDATA_W-1:0] pwdata = '0;
  logic [gdis_pkg::PDATA_W-1:0] prdata;
  logic              pready;

  genotype_decode_impute_standardize DUT (.*);

  always #5 clk = ~clk;

  // One expected output sample.
  typedef struct {
    logic [31:0] value;
    logic [11:0] index;
    logic        last;
  } zscore_t;

  zscore_t zscore_q[$];
  int          fail_count = 0;
  bit          quiet_rx = 0;    // receiver never stalls
  int          hold_cycles = 0; // long receiver hold-off
  bit          quiet_tx = 0;

  // Shadow state of the block.
  logic [1:0]  codes [gdis_pkg::MAX_SAMPLES];
  int unsigned cls_cnt [4];
  int unsigned loaded_bytes;
  int unsigned drain_pos;
  bit          draining;
  int unsigned marker_size;
  longint      lvl [3];

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0h expected %0h", what, got, want);
    fail_count++;
  endtask

  function automatic void clear_marker();
    for (int i = 0; i < 4; i++) cls_cnt[i] = 0;
    loaded_bytes = 0;
    drain_pos = 0;
    draining = 0;
  endfunction

  function automatic int unsigned major_class();
    int unsigned m;
    m = 0;
    if (cls_cnt[1] > cls_cnt[m]) m = 1;
    if (cls_cnt[2] > cls_cnt[m]) m = 2;
    return m;
  endfunction

  function automatic int unsigned cls_of(input logic [1:0] c);
    case (c)
      gdis_pkg::CODE_HOM0: return 0;
      gdis_pkg::CODE_HET:  return 1;
      gdis_pkg::CODE_HOM2: return 2;
      default:             return 3;
    endcase
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Mean and deviation of the imputed marker, then one value per genotype.
  function automatic void compute_zlevels();
    longint unsigned c [3];
    longint unsigned s, q, nq, ss, d, den, gn, mag, rq;
    int sh;
    bit neg;
    for (int i = 0; i < 3; i++) c[i] = cls_cnt[i];
    c[major_class()] += cls_cnt[3];
    s = c[1] + 2 * c[2];
    q = c[1] + 4 * c[2];
    nq = marker_size * q;
    ss = s * s;
    d = (nq > ss) ? nq - ss : 0;
    if (d > 0) begin
      den = int_sqrt(d << 30);
      sh = gdis_pkg::FRAC_BITS + gdis_pkg::SD_EXTRA;
    end else begin
      den = marker_size;
      sh = gdis_pkg::FRAC_BITS;
    end
    if (den == 0) den = 1;
    for (int g = 0; g < 3; g++) begin
      gn = g * marker_size;
      neg = gn < s;
      mag = neg ? s - gn : gn - s;
      rq = ((mag << sh) * 2 + den) / (2 * den);
      if (neg) lvl[g] = (rq > 64'd2147483648) ? -64'sd2147483648 : -longint'(rq);
      else lvl[g] = (rq > 64'd2147483647) ? 64'sd2147483647 : longint'(rq);
    end
  endfunction

  // Advances the shadow state by one accepted transaction.
  function automatic void predict_item(input logic mode, input logic [7:0] pb);
    int unsigned idx, cls;
    zscore_t z;
    if (mode == gdis_pkg::MODE_LOAD) begin
      if (draining) return;
      for (int i = 0; i < 4; i++) begin
        idx = loaded_bytes * 4 + i;
        if (idx < marker_size) begin
          codes[idx] = pb[2*i +: 2];
          cls_cnt[cls_of(pb[2*i +: 2])]++;
        end
      end
      loaded_bytes++;
      if (loaded_bytes * 4 >= marker_size) begin
        compute_zlevels();
        draining = 1;
        drain_pos = 0;
      end
    end else begin
      if (!draining) return;
      idx = drain_pos;
      cls = cls_of(codes[idx]);
      if (cls == 3) cls = major_class();
      z.value = lvl[cls][31:0];
      z.index = idx[11:0];
      z.last = (idx + 1 >= marker_size);
      zscore_q.insert(zscore_q.size(), z);
      if (z.last) clear_marker();
      else drain_pos = idx + 1;
    end
  endfunction

  task automatic apb_write(input logic [31:0] v);
    @(negedge clk);
    psel = 1; pwrite = 1; paddr = '0; pwdata = v; penable = 0;
    paddr[2] = gdis_pkg::REG_SAMPLE_COUNT;
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    marker_size = 32'(v[12:0]);
    if (marker_size == 0) marker_size = 1;
    if (marker_size > gdis_pkg::MAX_SAMPLES) marker_size = gdis_pkg::MAX_SAMPLES;
    clear_marker();
  endtask

  task automatic wait_drained();
    while (zscore_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Sends one transaction, with random gaps before it.
  task automatic send(input logic mode, input logic [7:0] pb);
    @(negedge clk);
    while (!quiet_tx && $urandom_range(0, 99) < 14) begin
      s_axis_tvalid = 0;
      @(negedge clk);
    end
    s_axis_tvalid = 1; s_axis_tuser = mode; s_axis_tdata = pb;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_item(mode, pb);
    @(negedge clk);
    s_axis_tvalid = 0;
  endtask

  // One full marker: loads then drains, with an occasional stray item.
  task automatic run_marker(input int kind);
    int unsigned nb;
    logic [7:0] b;
    nb = (marker_size + 3) / 4;
    for (int i = 0; i < nb; i++) begin
      case (kind)
        0: b = 8'($urandom_range(0, 255));
        1: b = 8'h55;
        2: b = {4{gdis_pkg::CODE_HOM2}};
        default: b = {gdis_pkg::CODE_HET, gdis_pkg::CODE_MISS,
                      gdis_pkg::CODE_HOM0, gdis_pkg::CODE_HET};
      endcase
      if ($urandom_range(0, 19) == 0) send(gdis_pkg::MODE_REQ, 8'($urandom_range(0, 255)));
      send(gdis_pkg::MODE_LOAD, b);
    end
    for (int i = 0; i < marker_size; i++) begin
      if ($urandom_range(0, 19) == 0) send(gdis_pkg::MODE_LOAD, 8'($urandom_range(0, 255)));
      send(gdis_pkg::MODE_REQ, 8'($urandom_range(0, 255)));
    end
  endtask

  // Receiver: random stalls, plus a counted hold-off.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet_rx || ($urandom_range(0, 99) >= 14);
    end
  end

  // Output checker.
  always @(posedge clk) begin
    zscore_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (zscore_q.size() == 0) begin
        report("unexpected output", m_axis_tdata, 0);
      end else begin
        w = zscore_q.pop_front();
        if (m_axis_tdata[31:0] !== w.value) report("value", m_axis_tdata[31:0], w.value);
        if (m_axis_tdata[43:32] !== w.index) report("index", m_axis_tdata[43:32], w.index);
        if (m_axis_tdata[47:44] !== 4'd0) report("pad", m_axis_tdata[47:44], 0);
        if (m_axis_tlast !== w.last) report("last", m_axis_tlast, w.last);
      end
    end
  end

  // Directed rows: sample count, marker pattern, and for one-sample markers
  // the value expected at a glance (-1 means use the predictor).
  typedef struct {
    int     count;
    int     kind;
    longint fixed_value;
  } row_t;

  row_t rows [8] = '{
    '{1, 2, 0}, '{1, 1, 0}, '{0, 0, 0}, '{3, 3, -1},
    '{4, 1, -1}, '{5, 2, -1}, '{7, 0, -1}, '{8191, 0, -1}
  };

  initial begin
    int     done_items;
    int     sizes [4];
    zscore_t z;
    sizes = '{4, 9, 13, 2};
    marker_size = 1;
    clear_marker();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed part: one sample after reset, extremes and odd patterns.
    foreach (rows[r]) begin
      if (r > 0) apb_write(rows[r].count);
      if (rows[r].fixed_value == 0 && marker_size == 1) begin
        send(gdis_pkg::MODE_REQ, 8'hFF);
        send(gdis_pkg::MODE_LOAD, (rows[r].kind == 2) ? 8'hFF : 8'h01);
        send(gdis_pkg::MODE_REQ, 8'h00);
        if (zscore_q.size() == 1) begin
          z = zscore_q[0];
          if (z.value !== 32'(rows[r].fixed_value) || z.last !== 1'b1)
            report("directed", z.value, rows[r].fixed_value);
        end else begin
          report("directed count", zscore_q.size(), 1);
        end
      end else if (rows[r].count < 100) begin
        run_marker(rows[r].kind);
      end else begin
        send(gdis_pkg::MODE_LOAD, 8'hC6);
        send(gdis_pkg::MODE_LOAD, 8'h1B);
      end
      wait_drained();
    end

    // A mid-size marker with the receiver held off so the block backs up.
    apb_write(40);
    hold_cycles = 300;
    run_marker(0);
    wait_drained();

    // Random part with small markers and a quiet stretch.
    done_items = 0;
    while (done_items < 450) begin
      apb_write($urandom_range(0, 9) == 0 ? $urandom_range(1, 64) : sizes[$urandom_range(0, 3)]);
      quiet_rx = (done_items > 200 && done_items < 300);
      quiet_tx = quiet_rx;
      run_marker($urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 3));
      done_items += marker_size + (marker_size + 3) / 4;
      if ($urandom_range(0, 3) == 0) begin
        // Abandon a partly loaded marker.
        send(gdis_pkg::MODE_LOAD, 8'($urandom_range(0, 255)));
      end
      wait_drained();
    end
    quiet_rx = 0;
    quiet_tx = 0;
    wait_drained();

    if (fail_count == 0 && zscore_q.size() == 0) begin
      $display("genotype_decode_impute_standardize verification clean");
    end else begin
      $display("genotype_decode_impute_standardize verification failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("genotype_decode_impute_standardize verification failed");
    $finish;
  end

endmodule
